FILE: src/qslp_pkg.sv
`default_nettype none
// Shared types, constants and the arctangent table for the quaternion interpolator.
package qslp_pkg;

	localparam int FRAC_BITS_DEF   = 30;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CORDIC_STEPS    = 31;
	localparam int DIV_STEPS       = 46;

	localparam logic [31:0] PI30       = 32'd3373259426;
	localparam logic [31:0] HALF_PI30  = 32'd1686629713;
	localparam logic [31:0] INV_GAIN30 = 32'd652032874;
	localparam logic [30:0] ONE30      = 31'h4000_0000;

	localparam logic        RESET_ADJUST_SIGN = 1'b1;
	localparam logic [30:0] RESET_THRESHOLD   = 31'd107374;

	localparam logic [7:0] REG_ADJUST_SIGN      = 8'd0;
	localparam logic [7:0] REG_LINEAR_THRESHOLD = 8'd1;

	typedef struct packed {
		logic signed [31:0] from_c0;
		logic signed [31:0] from_c1;
		logic signed [31:0] from_c2;
		logic signed [31:0] from_c3;
		logic signed [31:0] to_c0;
		logic signed [31:0] to_c1;
		logic signed [31:0] to_c2;
		logic signed [31:0] to_c3;
		logic [30:0]        interp_fraction;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] res_c0;
		logic signed [31:0] res_c1;
		logic signed [31:0] res_c2;
		logic signed [31:0] res_c3;
		logic               used_linear;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [31:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic [3:0][31:0] p;
		logic [3:0][32:0] q;
		logic [30:0]      t30;
		logic [31:0]      d30;
		logic             cand;
	} qentry_t;

	function automatic logic [31:0] atan_c(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'd843314857;
			1:  v = 32'd497837829;
			2:  v = 32'd263043837;
			3:  v = 32'd133525159;
			4:  v = 32'd67021687;
			5:  v = 32'd33543516;
			6:  v = 32'd16775851;
			7:  v = 32'd8388437;
			8:  v = 32'd4194283;
			9:  v = 32'd2097149;
			10: v = 32'd1048575;
			default: v = 32'(1) << (30 - i);
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: src/qslp_if.sv
`default_nettype none
// Valid/ready channel carrying one word of type T.
interface qslp_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/quaternion_slerp.sv
`default_nettype none
// Quaternion slerp (shortest path by default) in signed fixed point, top level.
// One word per cycle sustained on both channels while out_ch is ready. A word entering in_ch
// passes through the front end (input register, dot-product multiplier register, then sum,
// clamp and path choice into the output register), is written into the queue, then runs
// through a 150-stage back end whose length comes from the 31-step square root, the two
// 31-step CORDIC passes and the 46-step weight divider. A stall on out_ch freezes the back end;
// the front end keeps taking words until the four-entry queue fills.
module quaternion_slerp #(
	parameter int FRAC_BITS   = qslp_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = qslp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	qslp_if.sink   in_ch,
	qslp_if.sink   cfg,
	qslp_if.source out_ch
);
	import qslp_pkg::*;

	logic    q_push, q_full, q_pop, q_empty;
	qentry_t q_data, q_head;

	qslp_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	qslp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	qslp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (q_head),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

FILE: src/qslp_front.sv
`default_nettype none
// Front end: configuration registers, dot product, shortest-path sign fix and path selection.
module qslp_front #(
	parameter int FRAC_BITS = qslp_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	qslp_if.sink              in_ch,
	qslp_if.sink              cfg,
	input  logic              q_full,
	output logic              q_push,
	output qslp_pkg::qentry_t q_data
);
	import qslp_pkg::*;

	localparam int UP = 30 - FRAC_BITS;
	localparam logic [30:0] ONE_F = 31'(1) << FRAC_BITS;
	localparam logic signed [65:0] ONE66 = 66'sd1 <<< FRAC_BITS;

	logic        adjust_sign_q;
	logic [30:0] thr_q;
	logic        en;
	logic        v_s1, v_s2, v_s3;

	logic [3:0][31:0] p_s1, p_s2;
	logic [3:0][31:0] q_s1, q_s2;
	logic [30:0]      t30_s1, t30_s2;
	logic [3:0][63:0] prod_s2;
	qentry_t          e_d, e_s3;

	logic [30:0] tc;
	logic signed [65:0] dsum, dc, dadj, omin;
	logic neg;

	assign en       = !(v_s3 && q_full);
	assign in_ch.ready = en;
	assign cfg.ready   = 1'b1;
	assign q_push   = v_s3 && !q_full;
	assign q_data   = e_s3;

	assign tc = (in_ch.data.interp_fraction > ONE_F) ? ONE_F : in_ch.data.interp_fraction;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_sign_q <= RESET_ADJUST_SIGN;
			thr_q         <= RESET_THRESHOLD;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_ADJUST_SIGN:      adjust_sign_q <= cfg.data.value[0];
				REG_LINEAR_THRESHOLD: thr_q <= cfg.data.value[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= {in_ch.data.from_c3, in_ch.data.from_c2, in_ch.data.from_c1,
				in_ch.data.from_c0};
			q_s1   <= {in_ch.data.to_c3, in_ch.data.to_c2, in_ch.data.to_c1, in_ch.data.to_c0};
			t30_s1 <= tc << UP;
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= 64'($signed(p_s1[i]) * $signed(q_s1[i]));
			end
			p_s2   <= p_s1;
			q_s2   <= q_s1;
			t30_s2 <= t30_s1;
			e_s3   <= e_d;
		end
	end

	always_comb begin
		dsum = '0;
		for (int i = 0; i < 4; i++) begin
			dsum = dsum + 66'($signed(prod_s2[i]) >>> FRAC_BITS);
		end
		if (dsum > ONE66) begin
			dc = ONE66;
		end else if (dsum < -ONE66) begin
			dc = -ONE66;
		end else begin
			dc = dsum;
		end
		neg  = adjust_sign_q && (dc < 0);
		dadj = neg ? -dc : dc;
		omin = ONE66 - dadj;
		e_d.p = p_s2;
		for (int i = 0; i < 4; i++) begin
			e_d.q[i] = neg ? 33'(-$signed(q_s2[i])) : 33'($signed(q_s2[i]));
		end
		e_d.t30  = t30_s2;
		e_d.d30  = 32'(dadj <<< UP);
		e_d.cand = omin > $signed({35'b0, thr_q});
	end

endmodule
`default_nettype wire

FILE: src/qslp_queue.sv
`default_nettype none
// Short register queue between the front end and the interpolation pipeline.
module qslp_queue #(
	parameter int DEPTH = qslp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qslp_pkg::qentry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output qslp_pkg::qentry_t head
);
	import qslp_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qentry_t         mem_q [DEPTH];
	logic [IW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule
`default_nettype wire

FILE: src/qslp_back.sv
`default_nettype none
// Interpolation pipeline: square root, angle, sines, weight division and weighted sum.
module qslp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  qslp_pkg::qentry_t head,
	output logic              pop,
	qslp_if.source            out_ch
);
	import qslp_pkg::*;

	localparam int K_SQ0 = 2;
	localparam int K_VI  = K_SQ0 + CORDIC_STEPS;
	localparam int K_V0  = K_VI + 1;
	localparam int K_WC  = K_V0 + CORDIC_STEPS;
	localparam int K_AM  = K_WC + 1;
	localparam int K_RI  = K_AM + 1;
	localparam int K_R0  = K_RI + 1;
	localparam int K_DI  = K_R0 + CORDIC_STEPS;
	localparam int K_D0  = K_DI + 1;
	localparam int K_WS  = K_D0 + DIV_STEPS;
	localparam int K_PM  = K_WS + 1;
	localparam int K_CB  = K_PM + 1;
	localparam int K_SM  = K_CB + 1;
	localparam int NST   = K_SM + 1;

	typedef struct packed {
		logic [3:0][31:0]   p;
		logic [3:0][32:0]   q;
		logic [30:0]        t30;
		logic [31:0]        d30;
		logic               cand;
		logic [61:0]        dm2;
		logic [61:0]        sn;
		logic [61:0]        sr;
		logic signed [34:0] vx;
		logic signed [34:0] vy;
		logic signed [34:0] vz;
		logic [31:0]        w;
		logic [62:0]        mp;
		logic [62:0]        mq;
		logic [1:0][33:0]   rx;
		logic [1:0][33:0]   ry;
		logic [1:0][33:0]   rz;
		logic [1:0][30:0]   sv;
		logic [1:0][31:0]   rem;
		logic [1:0][45:0]   quo;
		logic               slerp;
		logic [45:0]        wp;
		logic [45:0]        wq;
		logic [7:0][31:0]   mag;
		logic [7:0]         neg;
		logic [7:0][54:0]   plo;
		logic [7:0][54:0]   phi;
		logic [7:0][62:0]   term;
		logic [3:0][31:0]   res;
	} bk_t;

	function automatic bk_t f_sq(input bk_t a);
		bk_t b;
		logic [30:0] m;
		b = a;
		m = a.d30[31] ? 31'(-$signed(a.d30)) : a.d30[30:0];
		b.dm2 = 62'(m) * 62'(m);
		return b;
	endfunction

	function automatic bk_t f_sinit(input bk_t a);
		bk_t b;
		b = a;
		b.sn = (62'(1) << 60) - a.dm2;
		b.sr = '0;
		return b;
	endfunction

	function automatic bk_t f_sqstep(input bk_t a, input int i);
		bk_t b;
		logic [61:0] bv, t;
		b  = a;
		bv = 62'(1) << (60 - 2 * i);
		t  = a.sr + bv;
		if (a.sn >= t) begin
			b.sn = a.sn - t;
			b.sr = (a.sr >> 1) + bv;
		end else begin
			b.sr = a.sr >> 1;
		end
		return b;
	endfunction

	function automatic bk_t f_vinit(input bk_t a);
		bk_t b;
		b = a;
		b.slerp = a.cand && (a.sr[30:0] != '0);
		if (a.d30[31]) begin
			b.vx = 35'(a.sr[30:0]);
			b.vy = -35'($signed(a.d30));
			b.vz = 35'(HALF_PI30);
		end else begin
			b.vx = 35'($signed(a.d30));
			b.vy = 35'(a.sr[30:0]);
			b.vz = '0;
		end
		return b;
	endfunction

	function automatic bk_t f_vstep(input bk_t a, input int i);
		bk_t b;
		logic signed [34:0] dx, dy, at;
		b  = a;
		dx = a.vy >>> i;
		dy = a.vx >>> i;
		at = $signed(35'(atan_c(i)));
		if (a.vy > 0) begin
			b.vx = a.vx + dx;
			b.vy = a.vy - dy;
			b.vz = a.vz + at;
		end else begin
			b.vx = a.vx - dx;
			b.vy = a.vy + dy;
			b.vz = a.vz - at;
		end
		return b;
	endfunction

	function automatic bk_t f_wclamp(input bk_t a);
		bk_t b;
		b = a;
		if (a.vz < 0) begin
			b.w = '0;
		end else if (a.vz > $signed(35'(PI30))) begin
			b.w = PI30;
		end else begin
			b.w = a.vz[31:0];
		end
		return b;
	endfunction

	function automatic bk_t f_angmul(input bk_t a);
		bk_t b;
		b = a;
		b.mp = 63'(a.w) * 63'(ONE30 - a.t30);
		b.mq = 63'(a.w) * 63'(a.t30);
		return b;
	endfunction

	function automatic bk_t f_rinit(input bk_t a);
		bk_t b;
		logic [32:0] ang;
		b = a;
		for (int l = 0; l < 2; l++) begin
			ang = (l == 0) ? a.mp[62:30] : a.mq[62:30];
			if (ang > 33'(HALF_PI30)) begin
				ang = 33'(PI30) - ang;
			end
			b.rx[l] = 34'(INV_GAIN30);
			b.ry[l] = '0;
			b.rz[l] = 34'(ang);
		end
		return b;
	endfunction

	function automatic bk_t f_rstep(input bk_t a, input int i);
		bk_t b;
		logic signed [33:0] x, y, z, dx, dy, at;
		b  = a;
		at = $signed(34'(atan_c(i)));
		for (int l = 0; l < 2; l++) begin
			x  = $signed(a.rx[l]);
			y  = $signed(a.ry[l]);
			z  = $signed(a.rz[l]);
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				b.rx[l] = x - dx;
				b.ry[l] = y + dy;
				b.rz[l] = z - at;
			end else begin
				b.rx[l] = x + dx;
				b.ry[l] = y - dy;
				b.rz[l] = z + at;
			end
		end
		return b;
	endfunction

	function automatic bk_t f_dinit(input bk_t a);
		bk_t b;
		logic signed [33:0] y;
		logic [30:0] s;
		b = a;
		for (int l = 0; l < 2; l++) begin
			y = $signed(a.ry[l]);
			if (y < 0) begin
				s = '0;
			end else if (y > 34'sd1073741824) begin
				s = ONE30;
			end else begin
				s = y[30:0];
			end
			b.sv[l]  = s;
			b.rem[l] = 32'(s[30:16]);
			b.quo[l] = '0;
		end
		return b;
	endfunction

	function automatic bk_t f_dstep(input bk_t a, input int j);
		bk_t b;
		logic [45:0] num;
		logic [32:0] tmp, dv;
		b  = a;
		dv = {2'b0, a.sr[30:0]};
		for (int l = 0; l < 2; l++) begin
			num = {a.sv[l][15:0], 30'b0};
			tmp = {a.rem[l], num[45 - j]};
			if (tmp >= dv) begin
				b.rem[l] = 32'(tmp - dv);
				b.quo[l] = {a.quo[l][44:0], 1'b1};
			end else begin
				b.rem[l] = tmp[31:0];
				b.quo[l] = {a.quo[l][44:0], 1'b0};
			end
		end
		return b;
	endfunction

	function automatic bk_t f_wsel(input bk_t a);
		bk_t b;
		b = a;
		if (a.slerp) begin
			b.wp = a.quo[0];
			b.wq = a.quo[1];
		end else begin
			b.wp = 46'(ONE30 - a.t30);
			b.wq = 46'(a.t30);
		end
		for (int i = 0; i < 4; i++) begin
			b.neg[i]     = a.p[i][31];
			b.mag[i]     = a.p[i][31] ? 32'(-a.p[i]) : a.p[i];
			b.neg[i + 4] = a.q[i][32];
			b.mag[i + 4] = a.q[i][32] ? 32'(-a.q[i]) : a.q[i][31:0];
		end
		return b;
	endfunction

	function automatic bk_t f_pmul(input bk_t a);
		bk_t b;
		logic [45:0] w;
		b = a;
		for (int k = 0; k < 8; k++) begin
			w = (k < 4) ? a.wp : a.wq;
			b.plo[k] = 55'(a.mag[k]) * 55'(w[22:0]);
			b.phi[k] = 55'(a.mag[k]) * 55'(w[45:23]);
		end
		return b;
	endfunction

	function automatic bk_t f_comb(input bk_t a);
		bk_t b;
		logic [77:0] full, cap;
		b = a;
		for (int k = 0; k < 8; k++) begin
			full = 78'(a.plo[k]) + (78'(a.phi[k]) << 23);
			cap  = (full > (78'(1) << 61)) ? (78'(1) << 61) : full;
			b.term[k] = a.neg[k] ? 63'(-cap) : 63'(cap);
		end
		return b;
	endfunction

	function automatic bk_t f_sum(input bk_t a);
		bk_t b;
		logic signed [63:0] s, r;
		b = a;
		for (int i = 0; i < 4; i++) begin
			s = 64'($signed(a.term[i])) + 64'($signed(a.term[i + 4])) + (64'sd1 <<< 29);
			r = s >>> 30;
			if (r > 64'sd2147483647) begin
				b.res[i] = 32'h7FFF_FFFF;
			end else if (r < -64'sd2147483648) begin
				b.res[i] = 32'h8000_0000;
			end else begin
				b.res[i] = r[31:0];
			end
		end
		return b;
	endfunction

	bk_t          hd;
	bk_t          stg_s [1:NST];
	logic [NST:1] vld_s;
	logic         adv;

	assign adv    = !vld_s[NST] || out_ch.ready;
	assign pop    = adv && !empty;

	always_comb begin
		hd      = '0;
		hd.p    = head.p;
		hd.q    = head.q;
		hd.t30  = head.t30;
		hd.d30  = head.d30;
		hd.cand = head.cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], !empty};
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		bk_t a, b;
		if (k == 0) begin : g_head
			assign a = hd;
		end else begin : g_prev
			assign a = stg_s[k];
		end
		always_comb begin
			if (k == 0) begin
				b = f_sq(a);
			end else if (k == 1) begin
				b = f_sinit(a);
			end else if (k < K_VI) begin
				b = f_sqstep(a, k - K_SQ0);
			end else if (k == K_VI) begin
				b = f_vinit(a);
			end else if (k < K_WC) begin
				b = f_vstep(a, k - K_V0);
			end else if (k == K_WC) begin
				b = f_wclamp(a);
			end else if (k == K_AM) begin
				b = f_angmul(a);
			end else if (k == K_RI) begin
				b = f_rinit(a);
			end else if (k < K_DI) begin
				b = f_rstep(a, k - K_R0);
			end else if (k == K_DI) begin
				b = f_dinit(a);
			end else if (k < K_WS) begin
				b = f_dstep(a, k - K_D0);
			end else if (k == K_WS) begin
				b = f_wsel(a);
			end else if (k == K_PM) begin
				b = f_pmul(a);
			end else if (k == K_CB) begin
				b = f_comb(a);
			end else begin
				b = f_sum(a);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[k + 1] <= b;
			end
		end
	end

	assign out_ch.valid            = vld_s[NST];
	assign out_ch.data.res_c0      = stg_s[NST].res[0];
	assign out_ch.data.res_c1      = stg_s[NST].res[1];
	assign out_ch.data.res_c2      = stg_s[NST].res[2];
	assign out_ch.data.res_c3      = stg_s[NST].res[3];
	assign out_ch.data.used_linear = !stg_s[NST].slerp;

endmodule
`default_nettype wire

FILE: tb/quaternion_slerp_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-point shortest-path quaternion interpolator.
module quaternion_slerp_tb;
	import qslp_pkg::*;

	localparam longint ONE       = 64'sd1 << 30;
	localparam longint PI_Q30    = 64'sd3373259426;
	localparam longint HALF_PI   = 64'sd1686629713;
	localparam longint INV_GAIN  = 64'sd652032874;
	localparam longint TERM_CAP  = 64'sd1 << 61;
	localparam int     LATENCY   = 160;
	localparam int     WATCHDOG  = 5000;
	localparam int     PHASES    = 5;
	localparam int     RAND_ITEMS = 140;

	localparam longint ARC_TAN [31] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048575, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1
	};

	typedef struct {
		in_word_t  stim;
		logic      typed;
		out_word_t result;
	} stim_row_t;

	logic clk;
	logic arst_n;

	qslp_if #(.T(in_word_t))  in_ch ();
	qslp_if #(.T(cfg_word_t)) cfg ();
	qslp_if #(.T(out_word_t)) out_ch ();

	quaternion_slerp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	logic        shortest_path;
	logic [30:0] lin_threshold;
	out_word_t   pending_q [$];
	int          fail_cnt;
	int          sent_cnt;
	int          quiet_cnt;
	logic        calm;
	logic        held_done;
	int          holdoff;
	stim_row_t   rows [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint z;
		longint nx;
		longint dx;
		longint dy;
		z = 0;
		if (x < 0) begin
			nx = y;
			y  = -x;
			x  = nx;
			z  = HALF_PI;
		end
		for (int i = 0; i < 31; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx; y = y - dy; z = z + ARC_TAN[i];
			end else begin
				x = x - dx; y = y + dy; z = z - ARC_TAN[i];
			end
		end
		if (z < 0) z = 0;
		if (z > PI_Q30) z = PI_Q30;
		return z;
	endfunction

	function automatic longint rotate_sine(longint a);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = INV_GAIN;
		y = 0;
		if (a > HALF_PI) a = PI_Q30 - a;
		z = a;
		for (int i = 0; i < 31; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - ARC_TAN[i];
			end else begin
				x = x + dx; y = y - dy; z = z + ARC_TAN[i];
			end
		end
		if (y < 0) y = 0;
		if (y > ONE) y = ONE;
		return y;
	endfunction

	function automatic longint scale_term(longint c, longint w);
		longint unsigned mag;
		longint unsigned uw;
		longint unsigned prod;
		mag = (c < 0) ? longint'(-c) : c;
		uw  = w;
		if (mag == 0 || uw == 0) return 0;
		if (mag > longint'(TERM_CAP) / uw) prod = TERM_CAP;
		else prod = mag * uw;
		if (prod > TERM_CAP) prod = TERM_CAP;
		return (c < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic out_word_t slerp_expect(in_word_t w);
		longint    p [4];
		longint    q [4];
		longint    r [4];
		longint    t;
		longint    dot;
		longint    wp;
		longint    wq;
		longint    s30;
		longint    ang;
		longint    sum;
		longint unsigned dmag;
		logic      lin;
		out_word_t o;
		p = '{w.from_c0, w.from_c1, w.from_c2, w.from_c3};
		q = '{w.to_c0, w.to_c1, w.to_c2, w.to_c3};
		t = w.interp_fraction;
		if (t > ONE) t = ONE;
		dot = 0;
		for (int i = 0; i < 4; i++)
			dot = dot + ((p[i] * q[i]) >>> 30);
		if (dot > ONE) dot = ONE;
		if (dot < -ONE) dot = -ONE;
		if (shortest_path && dot < 0) begin
			dot = -dot;
			for (int i = 0; i < 4; i++)
				q[i] = -q[i];
		end
		wp  = ONE - t;
		wq  = t;
		lin = 1'b1;
		if (ONE - dot > longint'(lin_threshold)) begin
			dmag = (dot < 0) ? -dot : dot;
			s30  = int_sqrt((64'd1 << 60) - dmag * dmag);
			if (s30 != 0) begin
				ang = vector_angle(dot, s30);
				wp  = (rotate_sine((ang * (ONE - t)) >>> 30) * ONE) / s30;
				wq  = (rotate_sine((ang * t) >>> 30) * ONE) / s30;
				lin = 1'b0;
			end
		end
		for (int i = 0; i < 4; i++) begin
			sum = scale_term(p[i], wp) + scale_term(q[i], wq) + (64'sd1 << 29);
			r[i] = sum >>> 30;
			if (r[i] > 64'sd2147483647) r[i] = 64'sd2147483647;
			if (r[i] < -64'sd2147483648) r[i] = -64'sd2147483648;
		end
		o.res_c0      = r[0][31:0];
		o.res_c1      = r[1][31:0];
		o.res_c2      = r[2][31:0];
		o.res_c3      = r[3][31:0];
		o.used_linear = lin;
		return o;
	endfunction

	function automatic in_word_t make_word(longint a0, longint a1, longint a2, longint a3,
			longint b0, longint b1, longint b2, longint b3, longint tf);
		in_word_t w;
		w.from_c0 = a0[31:0]; w.from_c1 = a1[31:0];
		w.from_c2 = a2[31:0]; w.from_c3 = a3[31:0];
		w.to_c0   = b0[31:0]; w.to_c1   = b1[31:0];
		w.to_c2   = b2[31:0]; w.to_c3   = b3[31:0];
		w.interp_fraction = tf[30:0];
		return w;
	endfunction

	function automatic logic signed [31:0] rand_comp(int mode);
		logic signed [31:0] v;
		v = $urandom;
		case (mode)
			0: v = v >>> 1;
			1: v = v >>> ($urandom_range(1, 20));
			default: ;
		endcase
		return v;
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		int       mode;
		mode = $urandom_range(0, 9);
		w.from_c0 = rand_comp(mode % 3); w.from_c1 = rand_comp(mode % 3);
		w.from_c2 = rand_comp(mode % 3); w.from_c3 = rand_comp(mode % 3);
		if (mode < 4) begin
			// close or opposite pair: drives the linear branch and the sign flip
			w.to_c0 = w.from_c0 + (rand_comp(1) >>> 8);
			w.to_c1 = w.from_c1 + (rand_comp(1) >>> 8);
			w.to_c2 = w.from_c2 + (rand_comp(1) >>> 8);
			w.to_c3 = w.from_c3 + (rand_comp(1) >>> 8);
			if (mode[0]) begin
				w.to_c0 = -w.to_c0; w.to_c1 = -w.to_c1;
				w.to_c2 = -w.to_c2; w.to_c3 = -w.to_c3;
			end
		end else begin
			w.to_c0 = rand_comp(mode % 3); w.to_c1 = rand_comp(mode % 3);
			w.to_c2 = rand_comp(mode % 3); w.to_c3 = rand_comp(mode % 3);
		end
		if ($urandom_range(0, 7) == 0) w.interp_fraction = $urandom;
		else w.interp_fraction = $urandom_range(0, 32'h4000_0000);
		return w;
	endfunction

	task automatic send_word(in_word_t w, logic typed, out_word_t result);
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		do @(posedge clk); while (!in_ch.ready);
		pending_q.push_back(typed ? result : slerp_expect(w));
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg.valid      <= 1'b1;
		cfg.data.index <= idx;
		cfg.data.value <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_ADJUST_SIGN) shortest_path = val[0];
		else if (idx == REG_LINEAR_THRESHOLD) lin_threshold = val[30:0];
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!held_done && sent_cnt >= 300) begin
			held_done <= 1'b1;
			holdoff   <= 400;
			out_ch.ready <= 1'b0;
		end else if (holdoff > 0) begin
			holdoff      <= holdoff - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t unexpected word %h", $realtime, out_ch.data);
				fail_cnt++;
			end else begin
				exp_w = pending_q.pop_front();
				if (out_ch.data.res_c0 !== exp_w.res_c0 || out_ch.data.res_c1 !== exp_w.res_c1 ||
						out_ch.data.res_c2 !== exp_w.res_c2 ||
						out_ch.data.res_c3 !== exp_w.res_c3 ||
						out_ch.data.used_linear !== exp_w.used_linear) begin
					$display("%0t mismatch expected %h %h %h %h %b actual %h %h %h %h %b",
						$realtime, exp_w.res_c0, exp_w.res_c1, exp_w.res_c2, exp_w.res_c3,
						exp_w.used_linear, out_ch.data.res_c0, out_ch.data.res_c1,
						out_ch.data.res_c2, out_ch.data.res_c3, out_ch.data.used_linear);
					fail_cnt++;
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || holdoff > 0)
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt > WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		out_word_t  exp_w;
		logic [31:0] thr_val [PHASES];
		logic        adj_val [PHASES];
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		cfg.valid     = 1'b0;
		cfg.data      = '0;
		out_ch.ready  = 1'b0;
		shortest_path = RESET_ADJUST_SIGN;
		lin_threshold = RESET_THRESHOLD;
		fail_cnt = 0; sent_cnt = 0; quiet_cnt = 0;
		calm = 1'b0; held_done = 1'b0; holdoff = 0;
		adj_val = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		thr_val = '{32'd107374, 32'd0, 32'h7FFF_FFFF, 32'h4000_0000, $urandom};

		exp_w = '{res_c0: 32'h4000_0000, res_c1: 0, res_c2: 0, res_c3: 0, used_linear: 1'b1};
		rows.push_back('{make_word(ONE, 0, 0, 0, ONE, 0, 0, 0, 0), 1'b1, exp_w});
		rows.push_back('{make_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, exp_w});
		rows.push_back('{make_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, exp_w});
		rows.push_back('{make_word(ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE / 2), 1'b0, exp_w});
		rows.push_back('{make_word(ONE, 0, 0, 0, 0, ONE, 0, 0, ONE / 2), 1'b0, exp_w});
		rows.push_back('{make_word(0, ONE, 0, 0, 0, 0, 0, -ONE, ONE / 3), 1'b0, exp_w});
		rows.push_back('{make_word(-2147483648, -2147483648, -2147483648, -2147483648,
			-2147483648, -2147483648, -2147483648, -2147483648, 31'h7FFF_FFFF), 1'b0, exp_w});
		rows.push_back('{make_word(2147483647, 2147483647, 2147483647, 2147483647,
			-2147483648, -2147483648, -2147483648, -2147483648, ONE / 4), 1'b0, exp_w});
		rows.push_back('{make_word(2147483647, -2147483648, 2147483647, -2147483648,
			2147483647, 2147483647, -2147483648, 0, 3), 1'b0, exp_w});
		rows.push_back('{make_word(ONE, 0, 0, 0, ONE - 50000, 200000, 0, 0, ONE / 2), 1'b0, exp_w});
		rows.push_back('{make_word(0, 0, ONE, 0, 0, 0, 7000, ONE, 31'h4000_0001), 1'b0, exp_w});
		rows.push_back('{make_word(ONE / 2, ONE / 2, ONE / 2, ONE / 2,
			-ONE / 2, ONE / 2, -ONE / 2, ONE / 2, ONE - 1), 1'b0, exp_w});

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				write_reg(REG_ADJUST_SIGN, {31'd0, adj_val[ph]});
				write_reg(REG_LINEAR_THRESHOLD, thr_val[ph]);
				cfg.valid <= 1'b0;
			end
			foreach (rows[k])
				send_word(rows[k].stim, rows[k].typed, rows[k].result);
			for (int k = 0; k < RAND_ITEMS; k++) begin
				calm = (ph == 2 && k >= 40 && k < 100);
				send_word(rand_word(), 1'b0, exp_w);
			end
			calm = 1'b0;
			drain();
		end

		repeat (LATENCY) @(negedge clk);
		if (fail_cnt == 0 && pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
src/qslp_pkg.sv
src/qslp_if.sv
src/qslp_front.sv
src/qslp_queue.sv
src/qslp_back.sv
src/quaternion_slerp.sv
tb/quaternion_slerp_tb.sv
